@@ hdl/btff_pkg.sv @@
// Shared constants, types and helpers for the boundary-tag first-fit allocator.
`timescale 1ns / 1ps
package btff_pkg;

    localparam int MAX_HEAP_BYTES = 4096;
    localparam int TAG_BYTES      = 4;
    localparam int ADDR_W         = $clog2(MAX_HEAP_BYTES);
    localparam int LEN_W          = $clog2(MAX_HEAP_BYTES + 1);
    localparam int TAG_W          = 17;
    localparam int SIZE_W         = 16;
    localparam int H_W            = 18;
    localparam int WA_W           = 20;
    localparam int MIN_HEAP_BYTES = 16;
    localparam int MIN_BLOCK      = 2 * TAG_BYTES;
    localparam int CFG_LEN_W      = 13;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_FORMAT = 2'd2,
        OP_NONE   = 2'd3
    } op_code_t;

    typedef enum logic [0:0] {
        REG_BASE_ADDRESS = 1'b0,
        REG_HEAP_BYTES   = 1'b1
    } reg_index_t;

    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LATCH,
        DP_CLR,
        DP_FMT_LATCH,
        DP_FW0,
        DP_FW1,
        DP_FW2,
        DP_RD_H,
        DP_WALK_A,
        DP_AW0,
        DP_AW1,
        DP_AW2,
        DP_AW3,
        DP_WALK_F,
        DP_RD_PREV,
        DP_TAKE_PREV,
        DP_RD_NEXT,
        DP_TAKE_NEXT,
        DP_FM0,
        DP_FM1
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_OK,
        RES_FAIL,
        RES_EMPTY
    } res_t;

    typedef struct packed {
        dp_op_t op;
        res_t   res;
    } cmd_t;

    typedef struct packed {
        logic     clr_done;
        logic     walk_stop;
        logic     req_zero;
        op_code_t op;
        logic     undersize;
        logic     fit;
        logic     split;
        logic     hit;
        logic     past;
        logic     tag_alloc;
        logic     h_zero;
        logic     out_busy;
    } status_t;

    function automatic logic [TAG_W-1:0] pack_tag(input logic [SIZE_W-1:0] size,
                                                  input logic alloc);
        return {alloc, size};
    endfunction

endpackage

@@ hdl/btff_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module btff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/btff_dp.sv @@
// Allocator datapath: registers, tag arithmetic, tag memory and result beat.
`timescale 1ns / 1ps
module btff_dp import btff_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic [1:0]  in_op,
    input  logic [15:0] in_req,
    input  logic [31:0] in_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_addr,
    output logic        out_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata
);

    logic [31:0]          base_cfg_reg;
    logic [CFG_LEN_W-1:0] len_cfg_reg;
    logic [31:0]          heap_base_reg;
    logic [LEN_W-1:0]     heap_len_reg;
    logic [LEN_W-1:0]     len_sat;
    op_code_t             op_reg;
    logic [15:0]          req_reg;
    logic [31:0]          addr_reg;
    logic [H_W-1:0]       h_reg;
    logic [SIZE_W-1:0]    s_reg;
    logic                 split_reg;
    logic [H_W-1:0]       start_reg;
    logic [H_W-1:0]       total_reg;
    logic                 oob_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic                 valid_reg;
    logic [31:0]          gaddr_reg;
    logic                 status_reg;

    logic [TAG_W-1:0]  rdata;
    logic [SIZE_W-1:0] size;
    logic [16:0]       need;
    logic [16:0]       rem_now;
    logic [16:0]       rem_reg;
    logic [SIZE_W-1:0] gsize;
    logic [31:0]       off;
    logic [31:0]       h4;
    logic [WA_W-1:0]   wa;
    logic [WA_W-1:0]   ra;
    logic [WA_W-1:0]   nxt;
    logic [TAG_W-1:0]  wd;
    logic              wen;
    logic              cfg_wr;

    assign size    = rdata[SIZE_W-1:0];
    assign need    = {1'b0, req_reg} + 17'(MIN_BLOCK);
    assign rem_now = {1'b0, size} - need;
    assign rem_reg = {1'b0, s_reg} - need;
    assign gsize   = split_reg ? need[SIZE_W-1:0] : s_reg;
    assign off     = addr_reg - heap_base_reg;
    assign h4      = 32'(h_reg) + 32'(TAG_BYTES);
    assign nxt     = WA_W'(h_reg) + WA_W'(s_reg);

    always_comb begin
        if (len_cfg_reg < CFG_LEN_W'(MIN_HEAP_BYTES)) begin
            len_sat = LEN_W'(MIN_HEAP_BYTES);
        end else if (32'(len_cfg_reg) > 32'(MAX_HEAP_BYTES)) begin
            len_sat = LEN_W'(MAX_HEAP_BYTES);
        end else begin
            len_sat = LEN_W'(len_cfg_reg);
        end
    end

    // status toward the controller
    always_comb begin
        st.clr_done  = clr_cnt_reg == ADDR_W'(MAX_HEAP_BYTES - 1);
        st.walk_stop = h4 > 32'(heap_len_reg);
        st.req_zero  = req_reg == '0;
        st.op        = op_reg;
        st.undersize = size < SIZE_W'(MIN_BLOCK);
        st.fit       = !rdata[SIZE_W] && ({1'b0, size} >= need);
        st.split     = split_reg;
        st.hit       = h4 == off;
        st.past      = h4 > off;
        st.tag_alloc = rdata[SIZE_W];
        st.h_zero    = h_reg == '0;
        st.out_busy  = valid_reg;
    end

    // tag memory addresses and write data
    always_comb begin
        wa  = '0;
        wd  = '0;
        wen = 1'b0;
        ra  = WA_W'(h_reg);
        unique case (cmd.op)
            DP_CLR: begin
                wen = 1'b1;
                wa  = WA_W'(clr_cnt_reg);
            end
            DP_FW0: begin
                wen = 1'b1;
                wd  = pack_tag(SIZE_W'(heap_len_reg - LEN_W'(TAG_BYTES)), 1'b0);
            end
            DP_FW1: begin
                wen = 1'b1;
                wa  = WA_W'(heap_len_reg) - WA_W'(2 * TAG_BYTES);
                wd  = pack_tag(SIZE_W'(heap_len_reg - LEN_W'(TAG_BYTES)), 1'b0);
            end
            DP_FW2: begin
                wen = 1'b1;
                wa  = WA_W'(heap_len_reg) - WA_W'(TAG_BYTES);
                wd  = pack_tag('0, 1'b1);
            end
            DP_AW0: begin
                wen = 1'b1;
                wa  = WA_W'(h_reg);
                wd  = pack_tag(gsize, 1'b1);
            end
            DP_AW1: begin
                wen = 1'b1;
                wa  = WA_W'(h_reg) + WA_W'(gsize) - WA_W'(TAG_BYTES);
                wd  = pack_tag(gsize, 1'b1);
            end
            DP_AW2: begin
                wen = 1'b1;
                wa  = WA_W'(h_reg) + WA_W'(need);
                wd  = pack_tag(rem_reg[SIZE_W-1:0], 1'b0);
            end
            DP_AW3: begin
                wen = 1'b1;
                wa  = WA_W'(h_reg) + WA_W'(s_reg) - WA_W'(TAG_BYTES);
                wd  = pack_tag(rem_reg[SIZE_W-1:0], 1'b0);
            end
            DP_FM0: begin
                wen = 1'b1;
                wa  = WA_W'(start_reg);
                wd  = pack_tag(total_reg[SIZE_W-1:0], 1'b0);
            end
            DP_FM1: begin
                wen = 1'b1;
                wa  = WA_W'(start_reg) + WA_W'(total_reg) - WA_W'(TAG_BYTES);
                wd  = pack_tag(total_reg[SIZE_W-1:0], 1'b0);
            end
            DP_RD_PREV: ra = WA_W'(h_reg) - WA_W'(TAG_BYTES);
            DP_RD_NEXT: ra = nxt;
            default: ra = WA_W'(h_reg);
        endcase
    end

    btff_ram #(
        .WIDTH(TAG_W),
        .DEPTH(MAX_HEAP_BYTES)
    ) u_tags (
        .aclk  (aclk),
        .we    (wen && (wa < WA_W'(MAX_HEAP_BYTES))),
        .waddr (wa[ADDR_W-1:0]),
        .wdata (wd),
        .raddr (ra[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_cfg_reg <= '0;
            len_cfg_reg  <= CFG_LEN_W'(MAX_HEAP_BYTES);
            clr_cnt_reg  <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_index_t'(paddr[2]))
                    REG_BASE_ADDRESS: base_cfg_reg <= pwdata;
                    REG_HEAP_BYTES:   len_cfg_reg  <= pwdata[CFG_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == DP_CLR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.res != RES_NONE) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_LATCH: begin
                op_reg   <= op_code_t'(in_op);
                req_reg  <= in_req;
                addr_reg <= in_addr;
                h_reg    <= '0;
            end
            DP_FMT_LATCH: begin
                heap_base_reg <= base_cfg_reg;
                heap_len_reg  <= len_sat;
            end
            DP_WALK_A: begin
                s_reg     <= size;
                split_reg <= rem_now >= 17'(MIN_BLOCK);
                if (!st.fit) begin
                    h_reg <= h_reg + H_W'(size);
                end
            end
            DP_WALK_F: begin
                s_reg     <= size;
                start_reg <= h_reg;
                total_reg <= H_W'(size);
                if (!st.hit) begin
                    h_reg <= h_reg + H_W'(size);
                end
            end
            DP_TAKE_PREV: begin
                if (!rdata[SIZE_W]) begin
                    start_reg <= h_reg - H_W'(size);
                    total_reg <= total_reg + H_W'(size);
                end
            end
            DP_RD_NEXT: oob_reg <= nxt >= WA_W'(MAX_HEAP_BYTES);
            DP_TAKE_NEXT: begin
                if (!oob_reg && !rdata[SIZE_W]) begin
                    total_reg <= total_reg + H_W'(size);
                end
            end
            default: ;
        endcase
        unique case (cmd.res)
            RES_OK: begin
                gaddr_reg  <= heap_base_reg + h4;
                status_reg <= 1'b0;
            end
            RES_FAIL: begin
                gaddr_reg  <= '0;
                status_reg <= 1'b1;
            end
            RES_EMPTY: begin
                gaddr_reg  <= '0;
                status_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (reg_index_t'(paddr[2]))
            REG_BASE_ADDRESS: prdata = base_cfg_reg;
            REG_HEAP_BYTES:   prdata = 32'(len_cfg_reg);
            default:          prdata = '0;
        endcase
    end

    assign out_valid  = valid_reg;
    assign out_addr   = gaddr_reg;
    assign out_status = status_reg;

endmodule

@@ hdl/btff_ctrl.sv @@
// Allocator controller: sequences clear, format, allocate walk and free merge.
`timescale 1ns / 1ps
module btff_ctrl import btff_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [20:0] {
        S_CLR   = 21'h000001,
        S_FL    = 21'h000002,
        S_FW0   = 21'h000004,
        S_FW1   = 21'h000008,
        S_FW2   = 21'h000010,
        S_IDLE  = 21'h000020,
        S_DISP  = 21'h000040,
        S_ARD   = 21'h000080,
        S_ACHK  = 21'h000100,
        S_AW0   = 21'h000200,
        S_AW1   = 21'h000400,
        S_AW2   = 21'h000800,
        S_AW3   = 21'h001000,
        S_FRD   = 21'h002000,
        S_FCHK  = 21'h004000,
        S_FPRD  = 21'h008000,
        S_FPCHK = 21'h010000,
        S_FNRD  = 21'h020000,
        S_FNCHK = 21'h040000,
        S_FM0   = 21'h080000,
        S_FM1   = 21'h100000
    } state_t;

    state_t state_reg, state_next;
    logic   fmt_res_reg, fmt_res_next;

    assign in_ready = (state_reg == S_IDLE) && !st.out_busy;

    always_comb begin
        state_next   = state_reg;
        fmt_res_next = fmt_res_reg;
        cmd.op       = DP_IDLE;
        cmd.res      = RES_NONE;
        unique case (state_reg)
            S_CLR: begin
                cmd.op = DP_CLR;
                if (st.clr_done) state_next = S_FL;
            end
            S_FL: begin
                cmd.op     = DP_FMT_LATCH;
                state_next = S_FW0;
            end
            S_FW0: begin
                cmd.op     = DP_FW0;
                state_next = S_FW1;
            end
            S_FW1: begin
                cmd.op     = DP_FW1;
                state_next = S_FW2;
            end
            S_FW2: begin
                cmd.op     = DP_FW2;
                cmd.res    = fmt_res_reg ? RES_EMPTY : RES_NONE;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (st.op)
                    OP_ALLOC: begin
                        if (st.req_zero) begin
                            cmd.res    = RES_FAIL;
                            state_next = S_IDLE;
                        end else begin
                            state_next = S_ARD;
                        end
                    end
                    OP_FREE: state_next = S_FRD;
                    OP_FORMAT: begin
                        fmt_res_next = 1'b1;
                        state_next   = S_FL;
                    end
                    default: begin
                        cmd.res    = RES_EMPTY;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ARD: begin
                cmd.op = DP_RD_H;
                if (st.walk_stop) begin
                    cmd.res    = RES_FAIL;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_ACHK;
                end
            end
            S_ACHK: begin
                cmd.op = DP_WALK_A;
                if (st.undersize) begin
                    cmd.res    = RES_FAIL;
                    state_next = S_IDLE;
                end else if (st.fit) begin
                    state_next = S_AW0;
                end else begin
                    state_next = S_ARD;
                end
            end
            S_AW0: begin
                cmd.op     = DP_AW0;
                state_next = S_AW1;
            end
            S_AW1: begin
                cmd.op = DP_AW1;
                if (st.split) begin
                    state_next = S_AW2;
                end else begin
                    cmd.res    = RES_OK;
                    state_next = S_IDLE;
                end
            end
            S_AW2: begin
                cmd.op     = DP_AW2;
                state_next = S_AW3;
            end
            S_AW3: begin
                cmd.op     = DP_AW3;
                cmd.res    = RES_OK;
                state_next = S_IDLE;
            end
            S_FRD: begin
                cmd.op = DP_RD_H;
                if (st.walk_stop) begin
                    cmd.res    = RES_EMPTY;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK: begin
                cmd.op = DP_WALK_F;
                // drop the free on a bad address or an already free block
                if (st.undersize || st.past || (st.hit && !st.tag_alloc)) begin
                    cmd.res    = RES_EMPTY;
                    state_next = S_IDLE;
                end else if (st.hit) begin
                    state_next = st.h_zero ? S_FNRD : S_FPRD;
                end else begin
                    state_next = S_FRD;
                end
            end
            S_FPRD: begin
                cmd.op     = DP_RD_PREV;
                state_next = S_FPCHK;
            end
            S_FPCHK: begin
                cmd.op     = DP_TAKE_PREV;
                state_next = S_FNRD;
            end
            S_FNRD: begin
                cmd.op     = DP_RD_NEXT;
                state_next = S_FNCHK;
            end
            S_FNCHK: begin
                cmd.op     = DP_TAKE_NEXT;
                state_next = S_FM0;
            end
            S_FM0: begin
                cmd.op     = DP_FM0;
                state_next = S_FM1;
            end
            S_FM1: begin
                cmd.op     = DP_FM1;
                cmd.res    = RES_EMPTY;
                state_next = S_IDLE;
            end
            default: state_next = S_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            fmt_res_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fmt_res_reg <= fmt_res_next;
        end
    end

endmodule

@@ hdl/boundary_tag_first_fit_allocator_top.sv @@
// Top level of the boundary-tag first-fit heap allocator.
//
// Input beats on s_*: s_tuser carries the op (allocate, free, format),
// s_tdata the request size and the payload address to free. Each input beat
// produces exactly one result beat on m_*: granted payload address in
// m_tdata, fail flag in m_tuser.
// Allocate walks the block tags, a tag read state and a check state per
// block, then writes two tags, or four when it splits; free walks the
// blocks, reads the neighbouring tags and writes two merged tags; format
// writes three tags. The tag memory has one read port with a registered read.
// One op is in flight at a time; s_tready is high only when the block is
// idle and the previous result beat has been taken.
// If the receiver stalls m_tready, the result beat holds and no new input
// beat is taken until it drains.
// After reset the tag memory is cleared, one entry per cycle over all 4096
// entries, then formatted from the current register values; s_tready stays low
// meanwhile. APB writes are taken at any time and apply at the next format.
`timescale 1ns / 1ps
module boundary_tag_first_fit_allocator_top import btff_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_bytes[15:0], block_address[47:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // granted_address[31:0]
    output logic [0:0]  m_tuser,   // status[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t    cmd;
    status_t st;

    assign pready = 1'b1;

    btff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    btff_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .in_op      (s_tuser),
        .in_req     (s_tdata[15:0]),
        .in_addr    (s_tdata[47:16]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (m_tdata),
        .out_status (m_tuser[0]),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata)
    );

endmodule

@@ hdl/btff_chk.sv @@
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
module btff_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed under stall");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("failed op carries an address");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready after accept");

endmodule

bind boundary_tag_first_fit_allocator_top btff_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
